// ===== hdl/bds_pkg.sv =====
// Package for the brush dab spacer: word types, state codes and fixed-point constants.
// Used by every module of the block; depends on nothing.
package bds_pkg;

    localparam int MaxDabs   = 64;
    localparam int DabCntW   = $clog2(MaxDabs + 1);
    localparam int MulW      = 33;
    localparam int ProdW     = 2 * MulW;
    localparam int DivSteps  = 17;
    localparam int SqrtSteps = 25;
    localparam int StepCntW  = 5;
    localparam int SumW      = 50;
    localparam int DistW     = 25;
    localparam int TotalW    = 26;
    localparam int StepW     = 29;
    localparam int FracW     = 17;

    localparam logic [23:0] Max24  = 24'hFFFFFF;
    localparam logic [StepW-1:0] HalfPx = StepW'(128);
    localparam logic [FracW-1:0] FracOne = FracW'(65536);

    typedef struct packed {
        logic signed [23:0] point_x;
        logic signed [23:0] point_y;
        logic [12:0]        pen_pressure;
        logic [15:0]        seg_width_start;
        logic [15:0]        seg_width_end;
        logic [11:0]        point_index;
        logic [12:0]        point_count;
    } t_point;

    typedef struct packed {
        logic signed [23:0] dab_x;
        logic signed [23:0] dab_y;
        logic [23:0]        dab_width;
        logic               last_dab;
    } t_dab;

    typedef enum logic [1:0] {
        CFG_GLOBAL_WIDTH = 2'd0,
        CFG_VIEW_SCALE   = 2'd1,
        CFG_DAB_SPACING  = 2'd2
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_IDLE, ST_TDIV, ST_IP0, ST_IP1, ST_IP2, ST_IF1, ST_IF2,
        ST_W1, ST_W2, ST_W3, ST_W4,
        ST_DX, ST_DY, ST_SUM, ST_SQ, ST_ST0, ST_ST1,
        ST_LOOP, ST_FDIV, ST_MX, ST_MY, ST_MW, ST_MS, ST_NS, ST_NS2,
        ST_OX, ST_OY, ST_OW, ST_EMIT, ST_FIN
    } t_state;

endpackage

// ===== hdl/bds_mul.sv =====
// Shared signed multiplier with a registered product.
// Depends on bds_pkg for operand and product widths.
module bds_mul
    import bds_pkg::*;
(
    input  logic                    i_clk,
    input  logic signed [MulW-1:0]  i_a,
    input  logic signed [MulW-1:0]  i_b,
    output logic signed [ProdW-1:0] o_prod
);

    logic signed [ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/bds_div.sv =====
// Restoring divider, one quotient bit per cycle, for a numerator not above the divisor.
// Gives floor(num * 65536 / den); depends on bds_pkg.
module bds_div
    import bds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [TotalW-1:0]  i_num,
    input  logic [DistW-1:0]   i_den,
    output logic               o_done,
    output logic [FracW-1:0]   o_quot
);

    logic                r_busy;
    logic                r_done;
    logic [StepCntW-1:0] r_cnt;
    logic [TotalW-1:0]   r_rem;
    logic [DistW-1:0]    r_den;
    logic [FracW-1:0]    r_q;
    logic                w_ge;
    logic [TotalW-1:0]   w_diff;

    assign w_ge   = r_rem >= {1'b0, r_den};
    assign w_diff = w_ge ? (r_rem - {1'b0, r_den}) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= StepCntW'(DivSteps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == StepCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[FracW-2:0], w_ge};
            r_rem <= {w_diff[TotalW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ===== hdl/bds_sqrt.sv =====
// Bit-pair integer square root, one result bit per cycle, rounding down.
// Depends on bds_pkg for widths and step count.
module bds_sqrt
    import bds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [SumW-1:0]   i_val,
    output logic              o_done,
    output logic [DistW-1:0]  o_root
);

    logic                r_busy;
    logic                r_done;
    logic [StepCntW-1:0] r_cnt;
    logic [SumW-1:0]     r_n;
    logic [SumW-1:0]     r_r;
    logic [SumW-1:0]     r_bit;
    logic [SumW-1:0]     w_trial;

    assign w_trial = r_r + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= StepCntW'(SqrtSteps);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == StepCntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n   <= i_val;
            r_r   <= '0;
            r_bit <= SumW'(1) << (SumW - 2);
        end else if (r_busy) begin
            if (r_n >= w_trial) begin
                r_n <= r_n - w_trial;
                r_r <= (r_r >> 1) + r_bit;
            end else begin
                r_r <= r_r >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_r[DistW-1:0];

endmodule

// ===== hdl/brush_dab_spacer_top.sv =====
// Top level of the brush dab spacer: sequencer, state and configuration registers.
// Depends on bds_pkg, bds_mul, bds_div and bds_sqrt.
//
//  channel | direction | handshake                  | word
//  point   | in        | i_in_valid / o_in_ready    | i_point (t_point)
//  dab     | out       | o_out_valid / i_out_ready  | o_dab (t_dab)
//  config  | in        | i_cfg_we                   | i_cfg_idx, i_cfg_data
//
// A start point skips the divides and the square root. A later point that makes no dab runs
// the position divide (skipped at the segment end), the square root, and the interpolation,
// width and chord products on the shared multiplier. Each dab adds a divide and products.
// One point at a time. Reset is synchronous and sets the state, configuration,
// previous-point and accumulator registers; no clearing pass is needed.
// A stalled dab holds the sequencer until it is taken.
module brush_dab_spacer_top
    import bds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_point      i_point,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_dab        o_dab,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);

    t_state r_state, n_state;

    logic [15:0]             r_gw, r_vs, r_sp;
    logic signed [23:0]      r_prev_x, r_prev_y;
    logic [12:0]             r_prev_p;
    logic [23:0]             r_prev_w, r_accum;
    t_point                  r_pt;
    logic                    r_first;
    logic [FracW-1:0]        r_t, r_f;
    logic signed [ProdW-1:0] r_acc;
    logic [12:0]             r_ip;
    logic [15:0]             r_ifac;
    logic [23:0]             r_wc, r_wi;
    logic signed [24:0]      r_dx, r_dy, r_xi, r_yi;
    logic [DistW-1:0]        r_d;
    logic [TotalW-1:0]       r_total;
    logic [StepW-1:0]        r_step, r_stepn;
    logic [DabCntW-1:0]      r_n;
    logic                    r_last;
    t_dab                    r_out;

    logic signed [MulW-1:0]  w_a, w_b;
    logic signed [ProdW-1:0] w_prod;
    logic                    w_div_start, w_div_done, w_sq_start, w_sq_done;
    logic [TotalW-1:0]       w_div_num;
    logic [DistW-1:0]        w_div_den;
    logic [FracW-1:0]        w_quot;
    logic [DistW-1:0]        w_root;
    logic                    w_accept, w_t_end, w_more;
    logic [12:0]             w_cnt_m1;
    logic signed [ProdW-1:0] w_rnd16, w_rnd12, w_interp;
    logic [ProdW-1:0]        w_wround;
    logic [23:0]             w_wc;
    logic signed [30:0]      w_num;
    logic [TotalW-1:0]       w_num_c;
    logic signed [26:0]      w_wsum;
    logic [23:0]             w_wi;
    logic signed [23:0]      w_osat;
    logic [StepW-1:0]        w_step0, w_stepn;
    logic [TotalW-1:0]       w_rest;

    bds_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_a),
        .i_b    (w_b),
        .o_prod (w_prod)
    );

    bds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    bds_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_val   (r_acc[SumW-1:0] + w_prod[SumW-1:0]),
        .o_done  (w_sq_done),
        .o_root  (w_root)
    );

    assign w_accept = i_in_valid && o_in_ready;
    assign w_cnt_m1 = i_point.point_count - 13'd1;
    assign w_t_end  = (i_point.point_count < 13'd2) || ({1'b0, i_point.point_index} >= w_cnt_m1);

    assign w_rnd16  = (w_prod + ProdW'(32768)) >>> 16;
    assign w_rnd12  = (w_prod + ProdW'(2048)) >>> 12;
    assign w_interp = (r_acc + w_prod + ProdW'(32768)) >>> 16;
    assign w_wround = ProdW'(w_prod) + (ProdW'(1) << 39);
    assign w_wc     = (|w_wround[ProdW-1:64]) ? Max24 : w_wround[63:40];

    assign w_osat = (w_rnd12 > ProdW'(signed'(8388607))) ? 24'sh7FFFFF :
                    (w_rnd12 < -ProdW'(signed'(8388608))) ? 24'sh800000 : w_rnd12[23:0];

    assign w_num   = 31'(signed'({2'b0, r_step})) + 31'(signed'({6'b0, r_d}))
                   - 31'(signed'({5'b0, r_total}));
    assign w_num_c = (w_num < 0) ? '0 :
                     (w_num > 31'(signed'({6'b0, r_d}))) ? TotalW'(r_d) : w_num[TotalW-1:0];

    assign w_wsum = 27'(signed'({3'b0, r_prev_w})) + w_rnd16[26:0];
    assign w_wi   = (w_wsum < 0) ? '0 : (|w_wsum[26:24]) ? Max24 : w_wsum[23:0];

    assign w_step0 = (w_prod[StepW+12:13] < HalfPx) ? HalfPx : w_prod[StepW+12:13];
    assign w_stepn = (w_prod[StepW+11:12] < HalfPx) ? HalfPx : w_prod[StepW+11:12];
    assign w_rest  = r_total - r_step[TotalW-1:0];
    assign w_more  = ({3'b0, r_total} >= r_step) && (r_n < DabCntW'(MaxDabs));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_point.point_index == '0) n_state = ST_W1;
                    else if (w_t_end)              n_state = ST_IP0;
                    else                           n_state = ST_TDIV;
                end
            end
            ST_TDIV: if (w_div_done) n_state = ST_IP0;
            ST_IP0:  n_state = ST_IP1;
            ST_IP1:  n_state = ST_IP2;
            ST_IP2:  n_state = ST_IF1;
            ST_IF1:  n_state = ST_IF2;
            ST_IF2:  n_state = ST_W1;
            ST_W1:   n_state = ST_W2;
            ST_W2:   n_state = ST_W3;
            ST_W3:   n_state = ST_W4;
            ST_W4:   n_state = r_first ? ST_OX : ST_DX;
            ST_DX:   n_state = ST_DY;
            ST_DY:   n_state = ST_SUM;
            ST_SUM:  n_state = ST_SQ;
            ST_SQ: begin
                if (w_sq_done) n_state = (w_root == '0) ? ST_FIN : ST_ST0;
            end
            ST_ST0:  n_state = ST_ST1;
            ST_ST1:  n_state = ST_LOOP;
            ST_LOOP: n_state = w_more ? ST_FDIV : ST_FIN;
            ST_FDIV: if (w_div_done) n_state = ST_MX;
            ST_MX:   n_state = ST_MY;
            ST_MY:   n_state = ST_MW;
            ST_MW:   n_state = ST_MS;
            ST_MS:   n_state = ST_NS;
            ST_NS:   n_state = ST_NS2;
            ST_NS2:  n_state = ST_OX;
            ST_OX:   n_state = ST_OY;
            ST_OY:   n_state = ST_OW;
            ST_OW:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (i_out_ready) n_state = r_first ? ST_FIN : ST_LOOP;
            end
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_a         = '0;
        w_b         = '0;
        w_div_start = 1'b0;
        w_div_num   = TotalW'(i_point.point_index);
        w_div_den   = DistW'(w_cnt_m1);
        w_sq_start  = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                w_div_start = i_in_valid && (i_point.point_index != '0) && !w_t_end;
            end
            ST_IP0: begin
                w_a = MulW'(r_prev_p);
                w_b = MulW'(FracOne - r_t);
            end
            ST_IP1: begin
                w_a = MulW'(r_pt.pen_pressure);
                w_b = MulW'(r_t);
            end
            ST_IP2: begin
                w_a = MulW'(r_pt.seg_width_start);
                w_b = MulW'(FracOne - r_t);
            end
            ST_IF1: begin
                w_a = MulW'(r_pt.seg_width_end);
                w_b = MulW'(r_t);
            end
            ST_W1: begin
                w_a = MulW'(r_ip);
                w_b = MulW'(r_ifac);
            end
            ST_W2: begin
                w_a = MulW'(r_gw);
                w_b = MulW'(r_vs);
            end
            ST_W3: begin
                w_a = r_acc[MulW-1:0];
                w_b = w_prod[MulW-1:0];
            end
            ST_DX: begin
                w_a = MulW'(r_dx);
                w_b = MulW'(r_dx);
            end
            ST_DY: begin
                w_a = MulW'(r_dy);
                w_b = MulW'(r_dy);
            end
            ST_SUM:  w_sq_start = 1'b1;
            ST_ST0: begin
                w_a = MulW'({1'b0, r_prev_w} + {1'b0, r_wc});
                w_b = MulW'(r_sp);
            end
            ST_LOOP: begin
                w_div_start = w_more;
                w_div_num   = w_num_c;
                w_div_den   = r_d;
            end
            ST_MX: begin
                w_a = MulW'(r_dx);
                w_b = MulW'(r_f);
            end
            ST_MY: begin
                w_a = MulW'(r_dy);
                w_b = MulW'(r_f);
            end
            ST_MW: begin
                w_a = MulW'(25'(signed'({1'b0, r_wc})) - 25'(signed'({1'b0, r_prev_w})));
                w_b = MulW'(r_f);
            end
            ST_NS: begin
                w_a = MulW'(r_wi);
                w_b = MulW'(r_sp);
            end
            ST_OX: begin
                w_a = MulW'(r_xi);
                w_b = MulW'(r_vs);
            end
            ST_OY: begin
                w_a = MulW'(r_yi);
                w_b = MulW'(r_vs);
            end
            ST_EMIT: o_out_valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_gw     <= 16'd4096;
            r_vs     <= 16'd4096;
            r_sp     <= 16'd1024;
            r_prev_x <= '0;
            r_prev_y <= '0;
            r_prev_p <= '0;
            r_prev_w <= '0;
            r_accum  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_GLOBAL_WIDTH: r_gw <= i_cfg_data;
                    CFG_VIEW_SCALE:   r_vs <= i_cfg_data;
                    CFG_DAB_SPACING:  r_sp <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_LOOP && !w_more) begin
                r_accum <= (|r_total[TotalW-1:24]) ? Max24 : r_total[23:0];
            end
            if (r_state == ST_FIN) begin
                r_prev_x <= r_pt.point_x;
                r_prev_y <= r_pt.point_y;
                r_prev_p <= r_pt.pen_pressure;
                r_prev_w <= r_wc;
                if (r_first) r_accum <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_pt    <= i_point;
                    r_first <= (i_point.point_index == '0);
                    r_ip    <= i_point.pen_pressure;
                    r_ifac  <= i_point.seg_width_start;
                    r_t     <= FracOne;
                    r_dx    <= 25'(i_point.point_x) - 25'(r_prev_x);
                    r_dy    <= 25'(i_point.point_y) - 25'(r_prev_y);
                end
            end
            ST_TDIV: if (w_div_done) r_t <= w_quot;
            ST_IP1:  r_acc <= w_prod;
            ST_IP2:  r_ip <= w_interp[12:0];
            ST_IF1:  r_acc <= w_prod;
            ST_IF2:  r_ifac <= w_interp[15:0];
            ST_W2:   r_acc <= w_prod;
            ST_W4: begin
                r_wc   <= w_wc;
                r_wi   <= w_wc;
                r_xi   <= 25'(r_pt.point_x);
                r_yi   <= 25'(r_pt.point_y);
                r_last <= 1'b1;
            end
            ST_DY:   r_acc <= w_prod;
            ST_SQ:   if (w_sq_done) r_d <= w_root;
            ST_ST1: begin
                r_step  <= w_step0;
                r_total <= TotalW'(r_accum) + TotalW'(r_d);
                r_n     <= '0;
            end
            ST_FDIV: if (w_div_done) r_f <= w_quot;
            ST_MY:   r_xi <= 25'(r_prev_x) + w_rnd16[24:0];
            ST_MW:   r_yi <= 25'(r_prev_y) + w_rnd16[24:0];
            ST_MS:   r_wi <= w_wi;
            ST_NS2: begin
                r_stepn <= w_stepn;
                r_last  <= !(({3'b0, w_rest} >= w_stepn)
                             && (r_n + 1'b1 < DabCntW'(MaxDabs)));
            end
            ST_OY:   r_out.dab_x <= w_osat;
            ST_OW: begin
                r_out.dab_y     <= w_osat;
                r_out.dab_width <= r_wi;
                r_out.last_dab  <= r_last;
            end
            ST_EMIT: begin
                if (i_out_ready && !r_first) begin
                    r_total <= w_rest;
                    r_step  <= r_stepn;
                    r_n     <= r_n + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_dab = r_out;

endmodule
